@@ sv/imu_fd_pkg.sv @@
package imu_fd_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_COMBO = 8'h61;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   localparam int STORE_DEPTH = 18;
   localparam int POS_W       = 5;

   localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
   localparam logic [POS_W-1:0] POS_TYPE   = 5'd1;
   localparam logic [POS_W-1:0] POS_DATA   = 5'd2;
   localparam logic [POS_W-1:0] SHORT_LAST = 5'd10;
   localparam logic [POS_W-1:0] LONG_LAST  = 5'd19;

   localparam logic [1:0] QTY_ACCEL = 2'd0;
   localparam logic [1:0] QTY_RATE  = 2'd1;
   localparam logic [1:0] QTY_ANGLE = 2'd2;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_LONG = 2'd3;

   typedef logic [7:0] byte_type;
   typedef byte_type [STORE_DEPTH-1:0] store_type;

endpackage

@@ sv/imu_frame_deframer_core.sv @@
// A frame's first result is offered in the cycle after its last byte is accepted.
// One byte is accepted per cycle unless the input stalls; a 20-byte frame yields three results.
// Input stalls only on a frame's last byte while results of the previous frame remain.
// Reset (synchronous, active high) returns to header hunt and empties the result slots;
// payload byte registers are not reset.
module imu_frame_deframer_core
   import imu_fd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_quantity,
   output logic signed [15:0] rsp_x_raw,
   output logic signed [15:0] rsp_y_raw,
   output logic signed [15:0] rsp_z_raw,
   output logic               rsp_long_format,
   output logic               rsp_last_of_frame
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             long_ff, long_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       sum_ff, sum_in;
   store_type        store_ff;
   store_type        snap_ff, snap_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             plong_ff, plong_in;
   logic [1:0]       pkind_ff, pkind_in;

   logic             req_fire, rsp_fire;
   logic             at_last;
   logic             wr_en;
   logic [POS_W-1:0] wr_idx;
   logic             done_long, done_short;
   logic [1:0]       qty;
   byte_type         b;

   assign b        = req_rx_byte;
   assign at_last  = (pos_ff >= POS_DATA) &&
                     (long_ff ? (pos_ff >= LONG_LAST) : (pos_ff >= SHORT_LAST));
   assign req_ready = !at_last || (cnt_ff == PEND_NONE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != PEND_NONE);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign wr_idx    = pos_ff - POS_DATA;

   // frame parser
   always_comb begin
      pos_in     = pos_ff;
      long_in    = long_ff;
      kind_in    = kind_ff;
      sum_in     = sum_ff;
      wr_en      = 1'b0;
      done_long  = 1'b0;
      done_short = 1'b0;
      if (req_fire) begin
         if (pos_ff == POS_HUNT) begin
            if (b == HDR_BYTE) begin
               pos_in = POS_TYPE;
               sum_in = b;
            end
         end else if (pos_ff == POS_TYPE) begin
            if (b == TYPE_COMBO) begin
               long_in = 1'b1;
               kind_in = QTY_ACCEL;
               sum_in  = sum_ff + b;
               pos_in  = POS_DATA;
            end else if (b inside {TYPE_ACCEL, TYPE_RATE, TYPE_ANGLE}) begin
               long_in = 1'b0;
               kind_in = 2'(b - TYPE_ACCEL);
               sum_in  = sum_ff + b;
               pos_in  = POS_DATA;
            end else begin
               long_in = 1'b0;
               kind_in = QTY_ACCEL;
               if (b == HDR_BYTE) begin
                  pos_in = POS_TYPE;
                  sum_in = b;
               end else begin
                  pos_in = POS_HUNT;
                  sum_in = 8'd0;
               end
            end
         end else if (long_ff) begin
            wr_en = (pos_ff <= LONG_LAST);
            if (pos_ff >= LONG_LAST) begin
               done_long = 1'b1;
               pos_in    = POS_HUNT;
               long_in   = 1'b0;
               kind_in   = QTY_ACCEL;
               sum_in    = 8'd0;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end else begin
            if (pos_ff >= SHORT_LAST) begin
               done_short = (sum_ff == b);
               pos_in     = POS_HUNT;
               kind_in    = QTY_ACCEL;
               sum_in     = 8'd0;
            end else begin
               wr_en  = 1'b1;
               sum_in = sum_ff + b;
               pos_in = pos_ff + 5'd1;
            end
         end
      end
   end

   // result slots
   always_comb begin
      cnt_in   = cnt_ff;
      plong_in = plong_ff;
      pkind_in = pkind_ff;
      snap_in  = snap_ff;
      if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
      end
      if (done_long || done_short) begin
         snap_in = store_ff;
         if (done_long) begin
            snap_in[STORE_DEPTH-1] = b;
         end
         cnt_in   = done_long ? PEND_LONG : PEND_ONE;
         plong_in = done_long;
         pkind_in = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HUNT;
         long_ff  <= 1'b0;
         kind_ff  <= QTY_ACCEL;
         sum_ff   <= 8'd0;
         cnt_ff   <= PEND_NONE;
         plong_ff <= 1'b0;
         pkind_ff <= QTY_ACCEL;
      end else begin
         pos_ff   <= pos_in;
         long_ff  <= long_in;
         kind_ff  <= kind_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         plong_ff <= plong_in;
         pkind_ff <= pkind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= b;
      end
      snap_ff <= snap_in;
   end

   assign qty = plong_ff ? 2'(PEND_LONG - cnt_ff) : pkind_ff;

   always_comb begin
      case (plong_ff ? qty : QTY_ACCEL)
         QTY_RATE: begin
            rsp_x_raw = {snap_ff[7],  snap_ff[6]};
            rsp_y_raw = {snap_ff[9],  snap_ff[8]};
            rsp_z_raw = {snap_ff[11], snap_ff[10]};
         end
         QTY_ANGLE: begin
            rsp_x_raw = {snap_ff[13], snap_ff[12]};
            rsp_y_raw = {snap_ff[15], snap_ff[14]};
            rsp_z_raw = {snap_ff[17], snap_ff[16]};
         end
         default: begin
            rsp_x_raw = {snap_ff[1], snap_ff[0]};
            rsp_y_raw = {snap_ff[3], snap_ff[2]};
            rsp_z_raw = {snap_ff[5], snap_ff[4]};
         end
      endcase
   end

   assign rsp_quantity      = qty;
   assign rsp_long_format   = plong_ff;
   assign rsp_last_of_frame = (cnt_ff == PEND_ONE);

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_long_load: assert property (@(posedge clock) disable iff (reset)
      (req_fire && long_ff && pos_ff == LONG_LAST) |=> (cnt_ff == PEND_LONG))
      else $error("long frame did not load three results");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= LONG_LAST) && (long_ff || pos_ff <= SHORT_LAST))
      else $error("byte position out of range");

   a_short_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_long_format) |-> (cnt_ff == PEND_ONE))
      else $error("short frame with more than one pending result");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && cnt_ff != PEND_ONE) |=> rsp_valid)
      else $error("long frame results lost");

endmodule
